### rtl/core/bounded_stack_with_search_macros.svh
// assertion macros for the bounded stack with search
// no dependencies; included by the top level
`ifndef BOUNDED_STACK_WITH_SEARCH_MACROS_SVH
`define BOUNDED_STACK_WITH_SEARCH_MACROS_SVH

// same-cycle implication, checked outside reset
`define BSWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BSWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bsws_pkg.sv
// shared types, codes and constants for the bounded stack with search
// no dependencies; used by every module of the block
`default_nettype none

package bsws_pkg;

    // default stack depth
    localparam int DEPTH_DEF = 16;

    // request kinds
    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    // request payload
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
    } t_req;

    // result payload
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic [3:0]         position;
        logic [4:0]         occupancy;
    } t_res;

    // datapath operations
    typedef enum logic [2:0] {
        DP_NONE,
        DP_LOAD,
        DP_PUSH,
        DP_POP,
        DP_SCAN_START,
        DP_SCAN_STEP
    } t_dp_op;

    // controller to datapath command
    typedef struct packed {
        t_dp_op     op;
        logic       res_load;
        logic [1:0] res_status;
        logic       sel_data;
        logic       sel_pos;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] kind;
        logic       empty;
        logic       full;
        logic       match;
        logic       last;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/core/bounded_stack_with_search.sv
// top level of the bounded stack with search: controller plus datapath
// depends on bsws_pkg, bsws_ctrl, bsws_datapath and the macros header
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------
//  request  | start high, busy low   | i_req  (kind, value)
//  result   | o_res_valid, 1 cycle   | o_res  (status, data,
//           |                        |   position, occupancy)
//
// push completes in its exec state; pop adds a wait state for its memory read;
// search steps the single read port one entry per cycle from index 0 until a
// hit or the top entry.
// the result strobe comes in the same cycle that busy drops; a new request may
// be taken in that same cycle. reset clears the fill count and the controller;
// entries are undefined until pushed. results cannot be stalled.
`default_nettype none

`include "bounded_stack_with_search_macros.svh"

module bounded_stack_with_search #(
    parameter int DEPTH = bsws_pkg::DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire bsws_pkg::t_req  i_req,
    output logic                 busy,
    output logic                 o_res_valid,
    output bsws_pkg::t_res       o_res
);

    bsws_pkg::t_dp_cmd  cmd;
    bsws_pkg::t_dp_stat stat;

    // sequencing
    bsws_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_res_valid)
    );

    // storage and compare
    bsws_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (o_res)
    );

    // checks
    `BSWS_ASSERT_NOW(a_res_when_idle, i_clk, i_rst_n, o_res_valid, !busy, "result while busy")
    `BSWS_ASSERT_NEXT(a_start_goes_busy, i_clk, i_rst_n, start && !busy, busy, "transfer not taken")
    `BSWS_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_res_valid, !o_res_valid, "double result")
    `BSWS_ASSERT_NOW(a_err_data_zero, i_clk, i_rst_n, o_res_valid && (o_res.status != bsws_pkg::ST_OK), o_res.data == 32'sd0, "data on failed request")

endmodule

`default_nettype wire

### rtl/core/bsws_datapath.sv
// stack datapath: entry memory, fill count, scan pointer and result register
// depends on bsws_pkg
`default_nettype none

module bsws_datapath #(
    parameter int DEPTH = bsws_pkg::DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bsws_pkg::t_req     i_req,
    input  wire bsws_pkg::t_dp_cmd  i_cmd,
    output bsws_pkg::t_dp_stat      o_stat,
    output bsws_pkg::t_res          o_res
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // entry memory, undefined until written
    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_data;

    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_cmp_idx, n_cmp_idx;
    logic [1:0]         r_kind;
    logic signed [31:0] r_value;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   top_idx;
    bsws_pkg::t_res     r_res;

    assign top_idx = IDX_W'(r_count - CNT_W'(1));

    // next count, scan pointer and read address
    always_comb begin
        n_count   = r_count;
        n_cmp_idx = r_cmp_idx;
        rd_addr   = r_cmp_idx;
        unique case (i_cmd.op)
            bsws_pkg::DP_PUSH: begin
                n_count = r_count + CNT_W'(1);
            end
            bsws_pkg::DP_POP: begin
                n_count = r_count - CNT_W'(1);
                rd_addr = top_idx;
            end
            bsws_pkg::DP_SCAN_START: begin
                n_cmp_idx = '0;
                rd_addr   = '0;
            end
            bsws_pkg::DP_SCAN_STEP: begin
                n_cmp_idx = r_cmp_idx + IDX_W'(1);
                rd_addr   = r_cmp_idx + IDX_W'(1);
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cmp_idx <= '0;
        end else begin
            r_count   <= n_count;
            r_cmp_idx <= n_cmp_idx;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == bsws_pkg::DP_LOAD) begin
            r_kind  <= i_req.kind;
            r_value <= i_req.value;
        end
    end

    // memory write on push, registered read every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == bsws_pkg::DP_PUSH) begin
            r_mem[IDX_W'(r_count)] <= r_value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res.status    <= i_cmd.res_status;
            r_res.data      <= i_cmd.sel_data ? r_rd_data : 32'sd0;
            r_res.position  <= i_cmd.sel_pos ? 4'(r_cmp_idx) : 4'd0;
            r_res.occupancy <= 5'(n_count);
        end
    end

    // status toward the controller
    always_comb begin
        o_stat.kind  = r_kind;
        o_stat.empty = (r_count == '0);
        o_stat.full  = (r_count == CNT_W'(DEPTH));
        o_stat.match = (r_rd_data == r_value);
        o_stat.last  = (r_cmp_idx == top_idx);
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

### rtl/core/bsws_ctrl.sv
// stack controller: sequences push, pop and search over the datapath
// depends on bsws_pkg
`default_nettype none

module bsws_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire bsws_pkg::t_dp_stat  i_stat,
    output bsws_pkg::t_dp_cmd        o_cmd,
    output logic                     o_busy,
    output logic                     o_done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_SCAN
    } t_state;

    t_state r_state, n_state;
    logic   r_done;

    // next state and datapath command
    always_comb begin
        n_state          = r_state;
        o_cmd.op         = bsws_pkg::DP_NONE;
        o_cmd.res_load   = 1'b0;
        o_cmd.res_status = bsws_pkg::ST_OK;
        o_cmd.sel_data   = 1'b0;
        o_cmd.sel_pos    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = bsws_pkg::DP_LOAD;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.kind)
                    bsws_pkg::KIND_PUSH: begin
                        o_cmd.res_load = 1'b1;
                        n_state        = S_IDLE;
                        if (i_stat.full) begin
                            o_cmd.res_status = bsws_pkg::ST_FULL;
                        end else begin
                            o_cmd.op = bsws_pkg::DP_PUSH;
                        end
                    end
                    bsws_pkg::KIND_POP: begin
                        if (i_stat.empty) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = bsws_pkg::ST_EMPTY;
                            n_state          = S_IDLE;
                        end else begin
                            o_cmd.op = bsws_pkg::DP_POP;
                            n_state  = S_POP_WAIT;
                        end
                    end
                    bsws_pkg::KIND_SEARCH: begin
                        if (i_stat.empty) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = bsws_pkg::ST_EMPTY;
                            n_state          = S_IDLE;
                        end else begin
                            o_cmd.op = bsws_pkg::DP_SCAN_START;
                            n_state  = S_SCAN;
                        end
                    end
                    default: begin
                        // unused kind: no-op with an ok result
                        o_cmd.res_load = 1'b1;
                        n_state        = S_IDLE;
                    end
                endcase
            end
            S_POP_WAIT: begin
                o_cmd.res_load = 1'b1;
                o_cmd.sel_data = 1'b1;
                n_state        = S_IDLE;
            end
            S_SCAN: begin
                priority if (i_stat.match) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.sel_pos  = 1'b1;
                    n_state        = S_IDLE;
                end else if (i_stat.last) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = bsws_pkg::ST_MISS;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.op = bsws_pkg::DP_SCAN_STEP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.res_load;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

`default_nettype wire

### tb/tb_bounded_stack_with_search.sv
// self-checking testbench for bounded_stack_with_search: push, pop and search requests
// are checked against a cycle-free mirror of the stack kept inside the testbench
// depends on bsws_pkg and the bounded_stack_with_search top level
module tb_bounded_stack_with_search;
    import bsws_pkg::*;

    localparam int STACK_DEPTH  = DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1225;

    // kind code 3 has no operation behind it and is treated as a no-op
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_res_valid;
    t_res o_res;

    int unsigned cycle_count = 0;

    // mirror of the stack: predicts the result of every accepted request
    class stack_mirror;
        logic signed [31:0] words [STACK_DEPTH];
        int unsigned        fill;
        t_res               pending_results [$];
        int unsigned        errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        // work out the result of one accepted request and queue it
        function void note_request(t_req r);
            t_res predicted;
            bit   hit;
            predicted = '0;
            hit       = 1'b0;
            case (r.kind)
                KIND_PUSH: begin
                    if (fill >= STACK_DEPTH) begin
                        predicted.status = ST_FULL;
                    end else begin
                        words[fill] = r.value;
                        fill++;
                    end
                end
                KIND_POP: begin
                    if (fill == 0) begin
                        predicted.status = ST_EMPTY;
                    end else begin
                        fill--;
                        predicted.data = words[fill];
                    end
                end
                KIND_SEARCH: begin
                    if (fill == 0) begin
                        predicted.status = ST_EMPTY;
                    end else begin
                        // lowest matching index among occupied entries only
                        for (int i = 0; i < fill; i++) begin
                            if (!hit && words[i] == r.value) begin
                                hit                = 1'b1;
                                predicted.position = 4'(i);
                            end
                        end
                        if (!hit) predicted.status = ST_MISS;
                    end
                end
                default: ;
            endcase
            predicted.occupancy = 5'(fill);
            pending_results.push_back(predicted);
        endfunction

        // compare one result transfer with the oldest prediction
        function void check_result(t_res got);
            t_res want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected: %p", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.data !== want.data) begin
                $display("%0t: data expected %0d actual %0d", $time, want.data, got.data);
                errors++;
            end
            if (got.position !== want.position) begin
                $display("%0t: position expected %0d actual %0d",
                         $time, want.position, got.position);
                errors++;
            end
            if (got.occupancy !== want.occupancy) begin
                $display("%0t: occupancy expected %0d actual %0d",
                         $time, want.occupancy, got.occupancy);
                errors++;
            end
        endfunction
    endclass

    stack_mirror mirror = new();

    bounded_stack_with_search #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req      (i_req),
        .busy       (busy),
        .o_res_valid(o_res_valid),
        .o_res      (o_res)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // request transfer seen at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) mirror.note_request(i_req);
    end

    // result transfer seen at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) mirror.check_result(o_res);
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // hold a request on the inputs until it is taken
    task automatic send_req(input logic [1:0] kind, input logic signed [31:0] value);
        start       <= 1'b1;
        i_req.kind  <= kind;
        i_req.value <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle_gap();
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    // stop sending until every predicted result has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (mirror.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // words drawn mostly from a small pool so that searches hit and repeat
    function automatic logic signed [31:0] pick_word();
        logic signed [31:0] pool [8];
        pool = '{WORD_MIN, WORD_MAX, 32'sd0, -32'sd1, 32'sd1, 32'sd5,
                 32'sh5555_5555, 32'shAAAA_AAAA};
        if ($urandom_range(99) < 70) return pool[$urandom_range(7)];
        return $urandom;
    endfunction

    // push share out of 67 sets whether the stack tends to fill or drain
    function automatic logic [1:0] pick_kind(input int push_share);
        int roll;
        roll = $urandom_range(99);
        if (roll < 3)               return KIND_UNUSED;
        if (roll < 33)              return KIND_SEARCH;
        if (roll < 33 + push_share) return KIND_PUSH;
        return KIND_POP;
    endfunction

    // stimulus
    initial begin
        logic signed [31:0] last_word;
        int                 push_share;
        push_share = 33;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty stack cases
        send_req(KIND_POP, $urandom);
        send_req(KIND_SEARCH, WORD_MIN);
        send_req(KIND_UNUSED, $urandom);
        // extremes, a duplicate, hits at low indexes and a miss
        send_req(KIND_PUSH, WORD_MIN);
        send_req(KIND_PUSH, WORD_MAX);
        send_req(KIND_PUSH, -32'sd1);
        send_req(KIND_PUSH, WORD_MIN);
        send_req(KIND_SEARCH, WORD_MIN);
        send_req(KIND_SEARCH, -32'sd1);
        send_req(KIND_SEARCH, 32'sd0);
        send_req(KIND_UNUSED, WORD_MAX);
        // fill up, push onto a full stack, search the top entry
        last_word = '0;
        for (int i = 4; i < STACK_DEPTH; i++) begin
            last_word = $urandom;
            send_req(KIND_PUSH, last_word);
        end
        send_req(KIND_PUSH, 32'sd7);
        send_req(KIND_SEARCH, last_word);
        wait_drained();

        // random part in phases that lean toward filling or draining or stay balanced
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(2))
                    0:       push_share = 55;
                    1:       push_share = 33;
                    default: push_share = 12;
                endcase
            end
            if (n == 300) wait_drained();
            else if (!(n >= 500 && n < 800) && $urandom_range(99) < 10) idle_gap();
            send_req(pick_kind(push_share), pick_word());
        end

        wait_drained();
        repeat (STACK_DEPTH + 4) @(posedge i_clk);
        if (mirror.errors == 0 && mirror.pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

### files.f
+incdir+rtl/core
rtl/core/bsws_pkg.sv
rtl/core/bsws_datapath.sv
rtl/core/bsws_ctrl.sv
rtl/core/bounded_stack_with_search.sv
tb/tb_bounded_stack_with_search.sv
